>>> src/stb_pkg.sv
// Shared types and constants of the software timer bank.
package stb_pkg;

   localparam int TIMER_COUNT = 8;
   localparam int SLOT_W      = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
   localparam int COUNT_W     = 16;
   localparam int INDEX_W     = 3;

   typedef enum logic [1:0] {
      MODE_TICK = 2'd0,
      MODE_SET  = 2'd1,
      MODE_POLL = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic               en;
      logic [SLOT_W-1:0]  slot;
      logic [COUNT_W-1:0] data;
   } mem_wr_type;

endpackage

>>> src/stb_if.sv
// Request and response channel interfaces of the software timer bank.
interface stb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [2:0]  timer_index;
   logic        preset_timeout;
   logic [15:0] load_value;

   modport source (output valid, mode, timer_index, preset_timeout, load_value,
                   input ready);
   modport sink   (input valid, mode, timer_index, preset_timeout, load_value,
                   output ready);
endinterface

interface stb_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] polled_index;
   logic       timed_out;

   modport source (output valid, polled_index, timed_out, input ready);
   modport sink   (input valid, polled_index, timed_out, output ready);
endinterface

>>> src/stb_count_mem.sv
// Count memory of the timer bank: one write port, one registered read port.
module stb_count_mem (
   input  logic                               clock,
   input  stb_pkg::mem_wr_type                wr,
   input  logic                               rd_en,
   input  logic [stb_pkg::SLOT_W-1:0]         rd_slot,
   output logic [stb_pkg::COUNT_W-1:0]        rd_data_ff
);

   logic [stb_pkg::COUNT_W-1:0] count_mem [stb_pkg::TIMER_COUNT];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         count_mem[wr.slot] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= count_mem[rd_slot];
      end
   end

endmodule

>>> src/software_timer_bank_core.sv
// Bank of countdown timers driven by tick, set and poll requests.
//
// The request channel carries one command per transfer: a tick decrements every
// running timer, a set loads one timer's count and timeout mark, a poll returns
// one timer's timeout mark on the response channel and clears it.
// Mode three is dropped without a response.
// A poll response appears in the cycle after its request transfer. A tick
// walks the timers one by one through a single shared decrementer and the
// count memory's one read and one write port, a read state and then a write
// state per timer; no request is taken until the walk is done.
// A new request is taken while a response is waiting only if that response
// is transferred in the same cycle; a stalled receiver holds the response and
// blocks further requests.
// Reset clears the running and timeout marks and any pending response; counts
// need no clearing since a timer only runs after a set has loaded it.
module software_timer_bank_core (
   input logic    clock,
   input logic    reset,
   stb_req_if.sink   req_bus,
   stb_rsp_if.source rsp_bus
);

   localparam int N = stb_pkg::TIMER_COUNT;

   stb_pkg::state_type          state_ff, state_in;
   logic [stb_pkg::SLOT_W-1:0]  cnt_ff, cnt_in;
   logic [N-1:0]                running_ff, running_in;
   logic [N-1:0]                expired_ff, expired_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [stb_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic                        rsp_timed_ff, rsp_timed_in;

   logic                        accept;
   logic [stb_pkg::SLOT_W-1:0]  req_slot;
   logic                        last_slot;
   logic                        rd_en;
   logic [stb_pkg::COUNT_W-1:0] rd_data;
   logic [stb_pkg::COUNT_W-1:0] dec_value;
   stb_pkg::mem_wr_type         mem_wr;

   assign req_slot  = stb_pkg::SLOT_W'(req_bus.timer_index % N);
   assign last_slot = (cnt_ff == stb_pkg::SLOT_W'(N - 1));
   assign accept    = req_bus.valid && req_bus.ready;
   assign dec_value = rd_data - stb_pkg::COUNT_W'(1);

   stb_count_mem u_mem (
      .clock      (clock),
      .wr         (mem_wr),
      .rd_en      (rd_en),
      .rd_slot    (cnt_ff),
      .rd_data_ff (rd_data)
   );

   // Next state of the tick sequencer.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         stb_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (accept && req_bus.mode == stb_pkg::MODE_TICK) begin
               state_in = stb_pkg::ST_READ;
            end
         end
         stb_pkg::ST_READ: begin
            state_in = stb_pkg::ST_WRITE;
         end
         stb_pkg::ST_WRITE: begin
            cnt_in = cnt_ff + stb_pkg::SLOT_W'(1);
            if (last_slot) begin
               state_in = stb_pkg::ST_IDLE;
            end else begin
               state_in = stb_pkg::ST_READ;
            end
         end
         default: begin
            state_in = stb_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer and the effect of each command.
   always_comb begin
      req_bus.ready = (state_ff == stb_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
      rd_en         = (state_ff == stb_pkg::ST_READ);
      mem_wr.en     = 1'b0;
      mem_wr.slot   = cnt_ff;
      mem_wr.data   = dec_value;
      running_in    = running_ff;
      expired_in    = expired_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_index_in  = rsp_index_ff;
      rsp_timed_in  = rsp_timed_ff;
      case (state_ff)
         stb_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_bus.mode)
                  stb_pkg::MODE_SET: begin
                     mem_wr.en            = 1'b1;
                     mem_wr.slot          = req_slot;
                     mem_wr.data          = req_bus.load_value;
                     running_in[req_slot] = 1'b1;
                     expired_in[req_slot] = req_bus.preset_timeout;
                  end
                  stb_pkg::MODE_POLL: begin
                     rsp_valid_in         = 1'b1;
                     rsp_index_in         = stb_pkg::INDEX_W'(req_slot);
                     rsp_timed_in         = expired_ff[req_slot];
                     expired_in[req_slot] = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         stb_pkg::ST_WRITE: begin
            // Only running timers count; an idle timer's entry may be unwritten.
            if (running_ff[cnt_ff]) begin
               mem_wr.en = 1'b1;
               if (dec_value == '0) begin
                  expired_in[cnt_ff] = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      rsp_bus.valid        = rsp_valid_ff;
      rsp_bus.polled_index = rsp_index_ff;
      rsp_bus.timed_out    = rsp_timed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stb_pkg::ST_IDLE;
         cnt_ff       <= '0;
         running_ff   <= '0;
         expired_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         running_ff   <= running_in;
         expired_ff   <= expired_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_timed_ff <= rsp_timed_in;
   end

endmodule

>>> src/stb_checker.sv
// Port-level checks of the timer bank core and their binding.
module stb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_mode,
   input logic [2:0] req_timer_index,
   input logic       req_preset_timeout,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_polled_index,
   input logic       rsp_timed_out
);

   logic req_xfer;
   assign req_xfer = req_valid && req_ready;

   // A waiting response stays until transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A poll transfer yields a response on the next cycle for the masked index.
   a_poll_rsp: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_mode == stb_pkg::MODE_POLL |=>
         rsp_valid && rsp_polled_index ==
            stb_pkg::INDEX_W'($past(req_timer_index) % stb_pkg::TIMER_COUNT))
      else $error("poll transfer without matching response");

   // A tick occupies the sequencer, so no request is taken in the next cycle.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_mode == stb_pkg::MODE_TICK |=> !req_ready)
      else $error("request taken during tick walk");

   // A set with the timeout mark cleared, polled right after, reports no timeout.
   a_set_poll: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_mode == stb_pkg::MODE_SET && !req_preset_timeout &&
      !$past(reset) ##1
      req_xfer && req_mode == stb_pkg::MODE_POLL &&
      $stable(req_timer_index) |=> rsp_valid && !rsp_timed_out)
      else $error("poll after set reported a timeout");

endmodule

bind software_timer_bank_core stb_checker u_stb_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .req_mode           (req_bus.mode),
   .req_timer_index    (req_bus.timer_index),
   .req_preset_timeout (req_bus.preset_timeout),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_polled_index   (rsp_bus.polled_index),
   .rsp_timed_out      (rsp_bus.timed_out)
);

>>> test/software_timer_bank_core_test.sv
// Self-checking testbench of the software timer bank: directed and random requests.
`timescale 1ns / 1ps

module software_timer_bank_core_test;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 2 * stb_pkg::TIMER_COUNT + 8;
   localparam int RANDOM_ITEMS = 550;

   typedef struct {
      logic [stb_pkg::INDEX_W-1:0] polled_index;
      logic                        timed_out;
   } poll_result_type;

   class timer_bank_scoreboard;
      logic [stb_pkg::COUNT_W-1:0] counts [stb_pkg::TIMER_COUNT];
      bit                 running [stb_pkg::TIMER_COUNT];
      bit                 expired [stb_pkg::TIMER_COUNT];
      poll_result_type    expected_polls [$];
      int                 errors;
      int                 ticks, sets, polls, ignored, timeouts_seen;

      function new();
         for (int k = 0; k < stb_pkg::TIMER_COUNT; k++) begin
            counts[k]  = '0;
            running[k] = 1'b0;
            expired[k] = 1'b0;
         end
         errors = 0;
         ticks = 0;
         sets = 0;
         polls = 0;
         ignored = 0;
         timeouts_seen = 0;
      endfunction

      // Applies one accepted request transfer to the predicted bank state.
      function void note_request(logic [1:0] mode, logic [stb_pkg::INDEX_W-1:0] index,
                                 logic preset, logic [stb_pkg::COUNT_W-1:0] load);
         int slot;
         poll_result_type res;
         slot = int'(index) % stb_pkg::TIMER_COUNT;
         case (mode)
            stb_pkg::MODE_TICK: begin
               ticks++;
               for (int k = 0; k < stb_pkg::TIMER_COUNT; k++) begin
                  if (running[k]) begin
                     counts[k] = counts[k] - 1'b1;
                     if (counts[k] == '0) expired[k] = 1'b1;
                  end
               end
            end
            stb_pkg::MODE_SET: begin
               sets++;
               counts[slot]  = load;
               running[slot] = 1'b1;
               expired[slot] = preset;
            end
            stb_pkg::MODE_POLL: begin
               polls++;
               res.polled_index = stb_pkg::INDEX_W'(slot);
               res.timed_out    = expired[slot];
               expected_polls.push_back(res);
               expired[slot] = 1'b0;
            end
            default: ignored++;
         endcase
      endfunction

      function void check_response(logic [stb_pkg::INDEX_W-1:0] index, logic flag);
         poll_result_type res;
         if (expected_polls.size() == 0) begin
            $error("Unexpected poll response: polled_index %0d timed_out %0d", index, flag);
            errors++;
            return;
         end
         res = expected_polls.pop_front();
         if (flag === 1'b1) timeouts_seen++;
         if (index !== res.polled_index) begin
            $error("polled_index mismatch: expected %0d actual %0d", res.polled_index, index);
            errors++;
         end
         if (flag !== res.timed_out) begin
            $error("timed_out mismatch: expected %0d actual %0d", res.timed_out, flag);
            errors++;
         end
      endfunction

      function int pending();
         return expected_polls.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   quiet;
   int   rsp_hold;
   int   drain_wait;
   int   counted;
   int   pick;
   timer_bank_scoreboard board;

   stb_req_if req_bus ();
   stb_rsp_if rsp_bus ();

   software_timer_bank_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("Verification failed");
      $finish;
   end

   // Mostly short gaps, now and then a long one; none during a quiet stretch.
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_request(input logic [1:0] mode,
                               input logic [stb_pkg::INDEX_W-1:0] index,
                               input logic preset,
                               input logic [stb_pkg::COUNT_W-1:0] load);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.mode           = mode;
      req_bus.timer_index    = index;
      req_bus.preset_timeout = preset;
      req_bus.load_value     = load;
      req_bus.valid          = 1'b1;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      board.note_request(mode, index, preset, load);
      @(negedge clock);
   endtask

   task automatic random_request();
      int r;
      logic [stb_pkg::COUNT_W-1:0] load;
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: load = stb_pkg::COUNT_W'($urandom_range(0, 4));
         5, 6:          load = stb_pkg::COUNT_W'($urandom_range(5, 40));
         default:       load = stb_pkg::COUNT_W'($urandom());
      endcase
      if (r < 30) begin
         send_request(stb_pkg::MODE_TICK, stb_pkg::INDEX_W'($urandom()), 1'($urandom()),
                      stb_pkg::COUNT_W'($urandom()));
      end else if (r < 60) begin
         send_request(stb_pkg::MODE_SET, stb_pkg::INDEX_W'($urandom()),
                      ($urandom_range(0, 3) == 0), load);
      end else if (r < 95) begin
         send_request(stb_pkg::MODE_POLL, stb_pkg::INDEX_W'($urandom()), 1'($urandom()),
                      stb_pkg::COUNT_W'($urandom()));
      end else begin
         send_request(MODE_UNUSED, stb_pkg::INDEX_W'($urandom()), 1'($urandom()),
                      stb_pkg::COUNT_W'($urandom()));
      end
   endtask

   // Response receiver stalls at random.
   initial begin
      rsp_bus.ready = 1'b0;
      rsp_hold = 0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready = 1'b0;
         end else if (rsp_hold > 0) begin
            rsp_bus.ready = 1'b0;
            rsp_hold--;
         end else begin
            rsp_bus.ready = 1'b1;
            if ($urandom_range(0, 2) == 0) rsp_hold = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         board.check_response(rsp_bus.polled_index, rsp_bus.timed_out);
      end
   end

   initial begin
      board = new();
      quiet = 1'b0;
      reset = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.mode           = stb_pkg::MODE_TICK;
      req_bus.timer_index    = '0;
      req_bus.preset_timeout = 1'b0;
      req_bus.load_value     = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The timeout marks of timers 0 and 7 are clear after reset.
      send_request(stb_pkg::MODE_POLL, 3'd0, 1'b0, 16'h0000);
      send_request(stb_pkg::MODE_POLL, 3'd7, 1'b1, 16'hFFFF);
      // A tick with no running timer changes nothing.
      send_request(stb_pkg::MODE_TICK, 3'd5, 1'b1, 16'hFFFF);
      // A load of zero wraps on the next tick without a timeout.
      send_request(stb_pkg::MODE_SET, 3'd0, 1'b0, 16'h0000);
      send_request(stb_pkg::MODE_TICK, 3'd0, 1'b0, 16'h0000);
      send_request(stb_pkg::MODE_POLL, 3'd0, 1'b0, 16'h0000);
      // A load of one times out on the next tick; the poll clears the mark.
      send_request(stb_pkg::MODE_SET, 3'd7, 1'b0, 16'h0001);
      send_request(stb_pkg::MODE_TICK, 3'd2, 1'b0, 16'h0000);
      send_request(stb_pkg::MODE_POLL, 3'd7, 1'b0, 16'h0000);
      send_request(stb_pkg::MODE_POLL, 3'd7, 1'b0, 16'h0000);
      // The timer keeps counting past its timeout.
      send_request(stb_pkg::MODE_TICK, 3'd0, 1'b0, 16'h0000);
      send_request(stb_pkg::MODE_POLL, 3'd7, 1'b0, 16'h0000);
      // Preset timeout mark with the largest count.
      send_request(stb_pkg::MODE_SET, 3'd3, 1'b1, 16'hFFFF);
      send_request(stb_pkg::MODE_POLL, 3'd3, 1'b1, 16'hFFFF);
      send_request(stb_pkg::MODE_POLL, 3'd3, 1'b0, 16'h0000);
      // The unused mode is dropped without a response.
      send_request(MODE_UNUSED, 3'd3, 1'b1, 16'hFFFF);
      send_request(stb_pkg::MODE_SET, 3'd5, 1'b0, 16'h0002);
      send_request(stb_pkg::MODE_TICK, 3'd7, 1'b1, 16'hAAAA);
      send_request(stb_pkg::MODE_POLL, 3'd5, 1'b0, 16'h5555);
      send_request(stb_pkg::MODE_TICK, 3'd1, 1'b0, 16'h5555);
      send_request(stb_pkg::MODE_POLL, 3'd5, 1'b0, 16'h0000);
      send_request(stb_pkg::MODE_POLL, 3'd6, 1'b0, 16'h0000);
      send_request(stb_pkg::MODE_POLL, 3'd4, 1'b0, 16'h0000);

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         quiet = ((counted / 60) % 4 == 1);
         pick = board.ignored;
         random_request();
         if (board.ignored == pick) counted++;
      end
      quiet = 1'b0;
      req_bus.valid = 1'b0;

      drain_wait = 0;
      while (board.pending() > 0 && drain_wait < 20000) begin
         @(posedge clock);
         drain_wait++;
      end
      if (board.pending() > 0) begin
         $error("%0d poll responses never arrived", board.pending());
         board.errors++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d ticks, %0d sets, %0d polls and %0d dropped requests.",
               board.ticks, board.sets, board.polls, board.ignored);
      $display("%0d polls reported a timeout.", board.timeouts_seen);
      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
